/* design/cesd_pkg.sv */
package cesd_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_value;
    logic       bad_escape;
    logic       byte_used;
    logic       last_of_run;
  } out_item_t;

  // All results caused by one input byte, queued as one entry.
  typedef struct packed {
    logic      two;
    out_item_t first;
    out_item_t second;
  } run_t;

  typedef struct packed {
    logic can_push;
    logic has_data;
  } q_stat_t;

endpackage

/* design/cesd_front.sv */
module cesd_front import cesd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  q_stat_t  q_stat,
  output logic     push,
  output run_t     push_run
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_BSL  = 3'd1,
    PH_HEX0 = 3'd2,
    PH_HEX1 = 3'd3,
    PH_OCT1 = 3'd4,
    PH_OCT2 = 3'd5
  } phase_t;

  localparam logic [7:0] CH_BSL = 8'h5C;
  localparam logic [7:0] CH_X   = 8'h78;
  localparam logic [7:0] CH_8   = 8'h38;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_NUL = 8'h00;

  phase_t     phase_r, phase_nxt;
  logic [5:0] accum_r, accum_nxt;

  logic [7:0] b;
  logic       eot;
  logic       take;
  logic       hex_ok;
  logic [3:0] hex_d;
  logic       oct_ok;
  logic [2:0] oct_d;
  logic       idle_plain;
  logic       idle_has;
  phase_t     idle_ph;
  out_item_t  idle_res;
  logic       has_res;
  logic       redo;
  out_item_t  res0;
  run_t       run;

  function automatic out_item_t mk(input logic [7:0] val, input logic bad, input logic used);
    out_item_t r;
    r.char_value  = bad ? 8'd0 : val;
    r.bad_escape  = bad;
    r.byte_used   = used;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  function automatic logic [7:0] simple_esc(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      "a":     r = 8'd7;
      "b":     r = 8'd8;
      "f":     r = 8'd12;
      "n":     r = 8'd10;
      "r":     r = 8'd13;
      "t":     r = 8'd9;
      "v":     r = 8'd11;
      default: r = c;
    endcase
    return r;
  endfunction

  assign b        = in_data.in_byte;
  assign eot      = in_data.end_of_text;
  assign in_ready = q_stat.can_push;
  assign take     = in_valid && in_ready;

  always_comb begin
    case (b) inside
      ["0":"9"]:           begin hex_ok = 1'b1; hex_d = b[3:0];        end
      ["a":"f"], ["A":"F"]: begin hex_ok = 1'b1; hex_d = b[3:0] + 4'd9; end
      default:             begin hex_ok = 1'b0; hex_d = 4'd0;          end
    endcase
  end

  assign oct_ok = (b[7:3] == 5'b00110);
  assign oct_d  = b[2:0];

  // Fresh decode of the byte as if no escape were pending.
  assign idle_plain = (b != CH_BSL);
  assign idle_has   = idle_plain || eot;
  assign idle_ph    = idle_has ? PH_IDLE : PH_BSL;
  assign idle_res   = mk(idle_plain ? b : 8'd0, !idle_plain, 1'b1);

  always_comb begin
    phase_nxt = PH_IDLE;
    accum_nxt = accum_r;
    has_res   = 1'b0;
    redo      = 1'b0;
    res0      = idle_res;
    case (phase_r)
      PH_BSL: begin
        if (b == CH_X) begin
          if (eot) begin
            has_res = 1'b1; res0 = mk(8'd0, 1'b1, 1'b1);
          end else begin
            phase_nxt = PH_HEX0;
          end
        end else if (b inside {CH_8, CH_9}) begin
          has_res = 1'b1; res0 = mk(b, 1'b0, 1'b1);
        end else if (oct_ok) begin
          if (eot) begin
            has_res = 1'b1; res0 = mk({5'd0, oct_d}, 1'b0, 1'b1);
          end else begin
            accum_nxt = {3'd0, oct_d};
            phase_nxt = PH_OCT1;
          end
        end else if (b == CH_NUL) begin
          has_res = 1'b1; res0 = mk(8'd0, 1'b1, 1'b1);
        end else begin
          has_res = 1'b1; res0 = mk(simple_esc(b), 1'b0, 1'b1);
        end
      end
      PH_HEX0: begin
        if (hex_ok) begin
          if (eot) begin
            has_res = 1'b1; res0 = mk({4'd0, hex_d}, 1'b0, 1'b1);
          end else begin
            accum_nxt = {2'd0, hex_d};
            phase_nxt = PH_HEX1;
          end
        end else begin
          has_res = 1'b1; redo = 1'b1; res0 = mk(8'd0, 1'b1, 1'b0);
        end
      end
      PH_HEX1: begin
        has_res = 1'b1;
        if (hex_ok) begin
          res0 = mk({accum_r[3:0], hex_d}, 1'b0, 1'b1);
        end else begin
          redo = 1'b1; res0 = mk({2'd0, accum_r}, 1'b0, 1'b0);
        end
      end
      PH_OCT1: begin
        if (oct_ok) begin
          if (eot) begin
            has_res = 1'b1; res0 = mk({2'd0, accum_r[2:0], oct_d}, 1'b0, 1'b1);
          end else begin
            accum_nxt = {accum_r[2:0], oct_d};
            phase_nxt = PH_OCT2;
          end
        end else begin
          has_res = 1'b1; redo = 1'b1; res0 = mk({2'd0, accum_r}, 1'b0, 1'b0);
        end
      end
      PH_OCT2: begin
        has_res = 1'b1;
        if (oct_ok) begin
          // first digit 4..7 overflows a byte
          res0 = mk({accum_r[4:0], oct_d}, accum_r[5], 1'b1);
        end else begin
          redo = 1'b1; res0 = mk({2'd0, accum_r}, 1'b0, 1'b0);
        end
      end
      default: begin
        has_res   = idle_has;
        res0      = idle_res;
        phase_nxt = idle_ph;
      end
    endcase
    if (redo) begin
      phase_nxt = idle_ph;
    end
  end

  always_comb begin
    run.two    = redo && idle_has;
    run.first  = res0;
    run.second = idle_res;
    if (run.two) begin
      run.second.last_of_run = 1'b1;
    end else begin
      run.first.last_of_run = 1'b1;
    end
  end

  assign push     = take && has_res;
  assign push_run = run;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      accum_r <= 6'd0;
    end else if (take) begin
      phase_r <= phase_nxt;
      accum_r <= accum_nxt;
    end
  end

endmodule

/* design/cesd_queue.sv */
module cesd_queue import cesd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  run_t    push_run,
  input  logic    pop,
  output run_t    head,
  output q_stat_t q_stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  run_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  assign head            = mem_r[rd_ptr_r];
  assign q_stat.can_push = (count_r != CW'(DEPTH));
  assign q_stat.has_data = (count_r != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_run;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      count_r <= count_nxt;
    end
  end

endmodule

/* design/cesd_back.sv */
module cesd_back import cesd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_stat_t   q_stat,
  input  run_t      head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      out_valid_r;
  logic      pend_r;
  out_item_t out_data_r;
  out_item_t second_r;
  logic      load;

  assign load      = !out_valid_r || out_ready;
  assign pop       = load && !pend_r && q_stat.has_data;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else if (load) begin
      if (pend_r) begin
        out_valid_r <= 1'b1;
        pend_r      <= 1'b0;
      end else begin
        out_valid_r <= q_stat.has_data;
        pend_r      <= q_stat.has_data && head.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_r) begin
        out_data_r <= second_r;
      end else if (q_stat.has_data) begin
        out_data_r <= head.first;
        second_r   <= head.second;
      end
    end
  end

endmodule

/* design/c_escape_sequence_decoder_core.sv */
// Decodes C character-literal text, one byte per input transfer, into
// character values: plain bytes, simple escapes, \x hex (one or two digits)
// and octal (one to three digits), flagging bad escapes with a zero value.
// The front decoder accepts a byte every cycle as long as its run queue
// (QUEUE_DEPTH entries) has room. A byte yields zero, one or two results;
// the output register drives one result per cycle while out_ready allows,
// so a byte that both closes an escape and is decoded afresh gives the
// output two results to send, and a long stretch of such bytes is paced by
// the output. Bytes that only advance an escape give no result. A result
// passes from the input transfer through a queue entry, then the output register.
module c_escape_sequence_decoder_core import cesd_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  q_stat_t q_stat;
  logic    push;
  run_t    push_run;
  logic    pop;
  run_t    head;

  // Front: escape state machine; each accepted byte that gives results
  // becomes one queue entry holding up to two results.
  cesd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (push),
    .push_run (push_run)
  );

  // Run queue decouples decode from output backpressure.
  cesd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_run (push_run),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // Back: splits each run into single result transfers.
  cesd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> q_stat.can_push)
    else $error("queue push while full");

  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_stat.has_data)
    else $error("queue pop while empty");

  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_data.last_of_run)
      |=> (out_valid && out_data.last_of_run))
    else $error("second result of a run did not follow");
`endif

endmodule
